// ===== sv/cbcl_pkg.sv =====
// Shared widths, command/status types and codes for the code block cache.
package cbcl_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned SIZE_W      = 20;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // read address counter operations
  typedef enum logic [2:0] {
    RA_HOLD = 3'd0,
    RA_ZERO = 3'd1,
    RA_N2   = 3'd2,
    RA_INC  = 3'd3,
    RA_DEC  = 3'd4
  } ra_op_e;

  // write port source select
  typedef enum logic [2:0] {
    WR_HIT        = 3'd0,
    WR_SHIFT      = 3'd1,
    WR_PLACE_UP   = 3'd2,
    WR_PLACE_ZERO = 3'd3,
    WR_APPEND     = 3'd4,
    WR_EVICT      = 3'd5
  } wr_sel_e;

  typedef struct packed {
    logic     latch_in;
    ra_op_e   ra_op;
    logic     rd_en;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     last_latch;
    logic     lru_upd;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic used_zero;
    logic used_lt2;
    logic full;
    logic rd_vld;
    logic match;
    logic rd_last;
    logic base_lt;
    logic rdi_zero;
    logic lru_end;
  } status_t;

endpackage

// ===== sv/code_block_cache_lru.sv =====
// Top level of the fully associative code block cache with LRU replacement.
//
//  channel   | direction | handshake                 | word
//  ----------+-----------+---------------------------+---------------------------------
//  request   | in        | start & !busy             | block_key_i, need_size_i,
//            |           |                           | now_time_i
//  result    | out       | done_o, one cycle         | hit_o, evicted_o, slot_o,
//            |           |                           | base_address_o
//  config    | in        | cfg_valid_i & cfg_ready_o | cfg_data_i (capacity)
//
//  An empty cache goes straight to the decide step. A hit finishes at the end
//  of the key scan. A miss scans every entry in use, sinks the newest entry into
//  base order, and then decides: it appends when not full, else it walks the
//  first cap entries for the LRU one and writes the replacement. The single read
//  port of the entry stores, one entry per cycle, paces each scan.
//  Reset clears entry count, bump address and control; capacity resets to 16.
//  No clearing pass. Results cannot be stalled; busy drops as done_o rises.
module code_block_cache_lru #(
  parameter int unsigned ENTRIES = cbcl_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [cbcl_pkg::KEY_W-1:0]    block_key_i,
  input  logic [cbcl_pkg::SIZE_W-1:0]   need_size_i,
  input  logic [cbcl_pkg::TIME_W-1:0]   now_time_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [cbcl_pkg::SLOT_W-1:0]   slot_o,
  output logic [cbcl_pkg::ADDR_W-1:0]   base_address_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbcl_pkg::CAP_W-1:0]    cfg_data_i
);
  import cbcl_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    busy_int;

  cbcl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy_int)
  );

  cbcl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .block_key_i    (block_key_i),
    .need_size_i    (need_size_i),
    .now_time_i     (now_time_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .slot_o         (slot_o),
    .base_address_o (base_address_o)
  );

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

endmodule

// ===== sv/cbcl_ctrl.sv =====
// Sequencer: hit scan, insertion of the newest entry, LRU search, final write.
module cbcl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  cbcl_pkg::status_t  status_i,
  output cbcl_pkg::cmd_t     cmd_o,
  output logic               busy
);
  import cbcl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_SHIFT  = 7'b0000100,
    ST_PLACE  = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_LRU    = 7'b0100000,
    ST_EVICT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o.latch_in    = 1'b0;
    cmd_o.ra_op       = RA_HOLD;
    cmd_o.rd_en       = 1'b0;
    cmd_o.wr_en       = 1'b0;
    cmd_o.wr_sel      = WR_HIT;
    cmd_o.last_latch  = 1'b0;
    cmd_o.lru_upd     = 1'b0;
    cmd_o.finish      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch_in = 1'b1;
          cmd_o.ra_op    = RA_ZERO;
          state_d        = status_i.used_zero ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra_op = RA_INC;
        if (status_i.rd_vld) begin
          if (status_i.match) begin
            cmd_o.rd_en  = 1'b0;
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_HIT;
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else if (status_i.rd_last) begin
            // miss: keep the newest entry aside and sink it into order
            cmd_o.rd_en      = 1'b0;
            cmd_o.last_latch = 1'b1;
            if (status_i.used_lt2) begin
              cmd_o.ra_op = RA_HOLD;
              state_d     = ST_DECIDE;
            end else begin
              cmd_o.ra_op = RA_N2;
              state_d     = ST_SHIFT;
            end
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra_op = RA_DEC;
        if (status_i.rd_vld) begin
          if (status_i.base_lt) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_SHIFT;
            if (status_i.rdi_zero) begin
              cmd_o.rd_en = 1'b0;
              state_d     = ST_PLACE;
            end
          end else begin
            cmd_o.rd_en  = 1'b0;
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_PLACE_UP;
            state_d      = ST_DECIDE;
          end
        end
      end
      ST_PLACE: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_PLACE_ZERO;
        state_d      = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.full) begin
          cmd_o.ra_op = RA_ZERO;
          state_d     = ST_LRU;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_APPEND;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_LRU: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra_op = RA_INC;
        if (status_i.rd_vld) begin
          cmd_o.lru_upd = 1'b1;
          if (status_i.lru_end) begin
            cmd_o.rd_en = 1'b0;
            state_d     = ST_EVICT;
          end
        end
      end
      ST_EVICT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_EVICT;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== sv/cbcl_dpath.sv =====
// Entry stores, read pipeline, bump allocator, LRU tracker and result register.
module cbcl_dpath #(
  parameter int unsigned ENTRIES = cbcl_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbcl_pkg::cmd_t                cmd_i,
  output cbcl_pkg::status_t             status_o,
  input  logic                          cfg_we_i,
  input  logic [cbcl_pkg::CAP_W-1:0]    cfg_data_i,
  input  logic [cbcl_pkg::KEY_W-1:0]    block_key_i,
  input  logic [cbcl_pkg::SIZE_W-1:0]   need_size_i,
  input  logic [cbcl_pkg::TIME_W-1:0]   now_time_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [cbcl_pkg::SLOT_W-1:0]   slot_o,
  output logic [cbcl_pkg::ADDR_W-1:0]   base_address_o
);
  import cbcl_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

  // entry stores
  logic [KEY_W-1:0]  mem_key_q  [ENTRIES];
  logic [TIME_W-1:0] mem_time_q [ENTRIES];
  logic [ADDR_W-1:0] mem_base_q [ENTRIES];

  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;
  logic [TIME_W-1:0] now_q;
  logic [CAP_W-1:0]  cap_q;
  logic [CW-1:0]     used_q;
  logic [ADDR_W-1:0] bump_q;
  logic [IW-1:0]     ra_q, ra_d;
  logic [IW-1:0]     rdi_q;
  logic              rd_vld_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic [TIME_W-1:0] rd_time_q;
  logic [ADDR_W-1:0] rd_base_q;
  logic [KEY_W-1:0]  last_key_q;
  logic [TIME_W-1:0] last_time_q;
  logic [ADDR_W-1:0] last_base_q;
  logic [IW-1:0]     best_slot_q;
  logic [TIME_W-1:0] best_time_q;
  logic [ADDR_W-1:0] best_base_q;
  logic              done_q;
  logic              hit_q;
  logic              evicted_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ADDR_W-1:0] base_q;

  logic [EW-1:0]     cap_ext;
  logic [EW-1:0]     cap_eff;
  logic [EW-1:0]     used_ext;
  logic [IW-1:0]     wr_addr;
  logic [KEY_W-1:0]  wr_key;
  logic [TIME_W-1:0] wr_time;
  logic [ADDR_W-1:0] wr_base;
  logic              is_append;

  // capacity zero acts as one, above the store size as the store size
  assign cap_ext  = EW'(cap_q);
  assign cap_eff  = (cap_ext == '0) ? EW'(1) :
                    (cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext;
  assign used_ext = EW'(used_q);

  assign status_o.used_zero = (used_q == '0);
  assign status_o.used_lt2  = (used_ext < EW'(2));
  assign status_o.full      = (used_ext >= cap_eff);
  assign status_o.rd_vld    = rd_vld_q;
  assign status_o.match     = (rd_key_q == key_q);
  assign status_o.rd_last   = ((EW'(rdi_q) + EW'(1)) == used_ext);
  assign status_o.base_lt   = (rd_base_q < last_base_q);
  assign status_o.rdi_zero  = (rdi_q == '0);
  assign status_o.lru_end   = ((EW'(rdi_q) + EW'(1)) == cap_eff);

  // read address: saturating walk keeps every read inside the store
  always_comb begin
    unique case (cmd_i.ra_op)
      RA_HOLD: ra_d = ra_q;
      RA_ZERO: ra_d = '0;
      RA_N2:   ra_d = IW'(used_ext - EW'(2));
      RA_INC:  ra_d = (ra_q == IW'(ENTRIES - 1)) ? ra_q : ra_q + IW'(1);
      RA_DEC:  ra_d = (ra_q == '0) ? ra_q : ra_q - IW'(1);
      default: ra_d = ra_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_HIT: begin
        wr_addr = rdi_q;
        wr_key  = rd_key_q;
        wr_time = now_q;
        wr_base = rd_base_q;
      end
      WR_SHIFT: begin
        wr_addr = rdi_q + IW'(1);
        wr_key  = rd_key_q;
        wr_time = rd_time_q;
        wr_base = rd_base_q;
      end
      WR_PLACE_UP: begin
        wr_addr = rdi_q + IW'(1);
        wr_key  = last_key_q;
        wr_time = last_time_q;
        wr_base = last_base_q;
      end
      WR_PLACE_ZERO: begin
        wr_addr = '0;
        wr_key  = last_key_q;
        wr_time = last_time_q;
        wr_base = last_base_q;
      end
      WR_APPEND: begin
        wr_addr = used_q[IW-1:0];
        wr_key  = key_q;
        wr_time = now_q;
        wr_base = bump_q;
      end
      WR_EVICT: begin
        wr_addr = best_slot_q;
        wr_key  = key_q;
        wr_time = now_q;
        wr_base = best_base_q;
      end
      default: begin
        wr_addr = '0;
        wr_key  = '0;
        wr_time = '0;
        wr_base = '0;
      end
    endcase
  end

  assign is_append = cmd_i.finish && (cmd_i.wr_sel == WR_APPEND);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_key_q[wr_addr]  <= wr_key;
      mem_time_q[wr_addr] <= wr_time;
      mem_base_q[wr_addr] <= wr_base;
    end
    rd_key_q  <= mem_key_q[ra_q];
    rd_time_q <= mem_time_q[ra_q];
    rd_base_q <= mem_base_q[ra_q];
    rdi_q     <= ra_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      key_q  <= block_key_i;
      size_q <= need_size_i;
      now_q  <= now_time_i;
    end
    if (cmd_i.last_latch) begin
      last_key_q  <= rd_key_q;
      last_time_q <= rd_time_q;
      last_base_q <= rd_base_q;
    end
    // first candidate seeds the search; ties keep the earlier slot
    if (cmd_i.lru_upd && ((rdi_q == '0) || (rd_time_q < best_time_q))) begin
      best_slot_q <= rdi_q;
      best_time_q <= rd_time_q;
      best_base_q <= rd_base_q;
    end
    if (cmd_i.finish) begin
      hit_q     <= (cmd_i.wr_sel == WR_HIT);
      evicted_q <= (cmd_i.wr_sel == WR_EVICT);
      slot_q    <= SLOT_W'(wr_addr);
      base_q    <= wr_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      used_q   <= '0;
      bump_q   <= '0;
      ra_q     <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (is_append) begin
        used_q <= used_q + CW'(1);
        bump_q <= bump_q + ADDR_W'(size_q);
      end
      ra_q     <= ra_d;
      rd_vld_q <= cmd_i.rd_en;
      done_q   <= cmd_i.finish;
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign evicted_o      = evicted_q;
  assign slot_o         = slot_q;
  assign base_address_o = base_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(ENTRIES))
    else $error("entry count beyond store size");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && (cmd_i.wr_sel == WR_APPEND)) |-> !status_o.full)
    else $error("append while full");

  a_bump_only_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_append |=> $stable(bump_q))
    else $error("bump address moved without an append");

  a_rd_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && (cmd_i.wr_sel == WR_HIT || cmd_i.wr_sel == WR_SHIFT ||
                     cmd_i.wr_sel == WR_PLACE_UP)) |-> rd_vld_q)
    else $error("write from stale read data");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held two cycles");

endmodule

// ===== tb/sv/cbcl_checker.sv =====
// Scoreboard for the code block cache: tracks capacity writes, predicts each reply and compares.
`timescale 1ns / 100ps
module cbcl_checker #(
  parameter int unsigned ENTRIES = cbcl_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [cbcl_pkg::KEY_W-1:0]  block_key_i,
  input  logic [cbcl_pkg::SIZE_W-1:0] need_size_i,
  input  logic [cbcl_pkg::TIME_W-1:0] now_time_i,
  input  logic                        done_i,
  input  logic                        hit_i,
  input  logic                        evicted_i,
  input  logic [cbcl_pkg::SLOT_W-1:0] slot_i,
  input  logic [cbcl_pkg::ADDR_W-1:0] base_address_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [cbcl_pkg::CAP_W-1:0]  cfg_data_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o
);
  import cbcl_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] base;
  } cache_reply_t;

  // shadow copy of the cache contents
  logic [KEY_W-1:0]  tag_mem  [ENTRIES];
  logic [TIME_W-1:0] use_mem  [ENTRIES];
  logic [ADDR_W-1:0] base_mem [ENTRIES];
  int unsigned       used_cnt;
  logic [ADDR_W-1:0] bump_ptr;
  logic [CAP_W-1:0]  cap_reg;
  cache_reply_t      reply_q [$];
  int unsigned       fail_cnt = 0;

  // stable insertion sort, highest base first
  function automatic void sort_by_base();
    int unsigned       j;
    logic [KEY_W-1:0]  k;
    logic [TIME_W-1:0] t;
    logic [ADDR_W-1:0] b;
    for (int unsigned i = 1; i < used_cnt; i++) begin
      k = tag_mem[i];
      t = use_mem[i];
      b = base_mem[i];
      j = i;
      while (j > 0 && base_mem[j-1] < b) begin
        tag_mem[j]  = tag_mem[j-1];
        use_mem[j]  = use_mem[j-1];
        base_mem[j] = base_mem[j-1];
        j--;
      end
      tag_mem[j]  = k;
      use_mem[j]  = t;
      base_mem[j] = b;
    end
  endfunction

  function automatic cache_reply_t serve_request(logic [KEY_W-1:0] key,
                                                 logic [SIZE_W-1:0] size,
                                                 logic [TIME_W-1:0] stamp);
    cache_reply_t      r;
    int unsigned       cap;
    int unsigned       victim;
    logic [TIME_W-1:0] oldest;
    r = '0;
    if (cap_reg == '0) cap = 1;
    else if (cap_reg > ENTRIES) cap = ENTRIES;
    else cap = 32'(cap_reg);

    for (int unsigned i = 0; i < used_cnt; i++) begin
      if (tag_mem[i] == key) begin
        use_mem[i] = stamp;
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i);
        r.base = base_mem[i];
        return r;
      end
    end

    sort_by_base();

    if (used_cnt >= cap) begin
      // only the first cap entries compete; strict less keeps the earliest on a tie
      victim = 0;
      oldest = use_mem[0];
      for (int unsigned i = 1; i < cap; i++) begin
        if (use_mem[i] < oldest) begin
          oldest = use_mem[i];
          victim = i;
        end
      end
      tag_mem[victim] = key;
      use_mem[victim] = stamp;
      r.evicted = 1'b1;
      r.slot    = SLOT_W'(victim);
      r.base    = base_mem[victim];
      return r;
    end

    tag_mem[used_cnt]  = key;
    use_mem[used_cnt]  = stamp;
    base_mem[used_cnt] = bump_ptr;
    r.slot   = SLOT_W'(used_cnt);
    r.base   = bump_ptr;
    bump_ptr = bump_ptr + ADDR_W'(size);
    used_cnt++;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t want;
    if (!rst_ni) begin
      used_cnt = 0;
      bump_ptr = '0;
      cap_reg  = CAP_RESET;
      reply_q.delete();
    end else begin
      if (done_i) begin
        if (reply_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected reply word: hit %0b evicted %0b slot %0d base %h",
                     $time, hit_i, evicted_i, slot_i, base_address_i);
        end else begin
          want = reply_q.pop_front();
          if (hit_i !== want.hit || evicted_i !== want.evicted ||
              slot_i !== want.slot || base_address_i !== want.base) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: reply mismatch: exp %0b %0b %0d %h, got %0b %0b %0d %h",
                       $time, want.hit, want.evicted, want.slot, want.base,
                       hit_i, evicted_i, slot_i, base_address_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_data_i;
      if (start_i && !busy_i)
        reply_q.push_back(serve_request(block_key_i, need_size_i, now_time_i));
    end
    errors_o  <= fail_cnt;
    pending_o <= reply_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, request and capacity stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
  import cbcl_pkg::*;

  localparam int unsigned WATCH_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 3 * ENTRIES_DEF + 8;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned NPHASE       = 7;
  localparam int unsigned POOL         = 24;
  localparam logic [CAP_W-1:0] PHASE_CAP [NPHASE-1] =
    '{5'd16, 5'd1, 5'd9, 5'd0, 5'd31, 5'd5};

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic [KEY_W-1:0]  block_key = '0;
  logic [SIZE_W-1:0] need_size = '0;
  logic [TIME_W-1:0] now_time  = '0;
  logic              cfg_valid = 1'b0;
  logic [CAP_W-1:0]  cfg_data  = '0;

  logic              busy;
  logic              done;
  logic              hit;
  logic              evicted;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] base_address;
  logic              cfg_ready;

  int unsigned       errors;
  int unsigned       pending;
  int unsigned       idle_cycles = 0;
  bit                gaps_on = 1'b1;
  logic [KEY_W-1:0]  key_pool [POOL];
  logic [KEY_W-1:0]  last_key = '0;
  logic [TIME_W-1:0] clock_now = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  code_block_cache_lru dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .block_key_i    (block_key),
    .need_size_i    (need_size),
    .now_time_i     (now_time),
    .done_o         (done),
    .hit_o          (hit),
    .evicted_o      (evicted),
    .slot_o         (slot),
    .base_address_o (base_address),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  cbcl_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .block_key_i    (block_key),
    .need_size_i    (need_size),
    .now_time_i     (now_time),
    .done_i         (done),
    .hit_i          (hit),
    .evicted_i      (evicted),
    .slot_i         (slot),
    .base_address_i (base_address),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size,
                              logic [TIME_W-1:0] stamp);
    start     <= 1'b1;
    block_key <= key;
    need_size <= size;
    now_time  <= stamp;
    last_key  = key;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap();
    int unsigned n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every reply is back; pending is registered, so step first
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] stamp;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) key = key_pool[$urandom_range(0, POOL - 1)];
    else if (pick < 8) key = last_key;
    else key = $urandom;

    pick = $urandom_range(0, 4);
    if (pick == 0) size = '0;
    else if (pick == 1) size = '1;
    else size = SIZE_W'($urandom);

    // mostly rising time with repeats, so LRU ties show up
    clock_now = clock_now + TIME_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 7);
    if (pick < 4) stamp = clock_now;
    else if (pick < 6) stamp = $urandom;
    else if (pick == 6) stamp = '0;
    else stamp = '1;

    send_request(key, size, stamp);
  endtask

  initial begin
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity zero behaves as one entry
    write_capacity(5'd0);
    send_request(32'h0000_0000, 20'h00000, 32'd100);
    send_request(32'h0000_0000, 20'h00000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);

    // equal times and equal bases, then a hit with time zero: that entry is evicted
    write_capacity(5'd4);
    send_request(32'h0000_0001, 20'hFFFFF, 32'd5);
    send_request(32'h0000_0002, 20'h00000, 32'd5);
    send_request(32'h0000_0003, 20'h00001, 32'd5);
    send_request(32'h0000_0004, 20'h00010, 32'd5);
    send_request(32'h0000_0001, 20'h00000, 32'h0000_0000);
    send_request(32'h0000_0005, 20'h12345, 32'hFFFF_FFFF);

    // above the entry count clamps to full size
    write_capacity(5'd31);
    send_request(32'h0000_0006, 20'h00000, 32'h0000_0000);
    send_request(32'h0000_0007, 20'hFFFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0008, 20'h00000, 32'h8000_0000);
    send_request(32'h0000_0009, 20'hAAAAA, 32'h0000_0001);
    send_request(32'h0000_000A, 20'h55555, 32'h7FFF_FFFF);
    send_request(32'h0000_000B, 20'hFFFFF, 32'h0000_0002);
    send_request(32'h0000_000C, 20'h00001, 32'h0000_0003);
    send_request(32'h0000_000C, 20'h00000, 32'h0000_0004);

    // capacity below the entries in use: hits still see every entry
    write_capacity(5'd2);
    send_request(32'hAAAA_AAAA, 20'h00000, 32'h0000_0010);
    send_request(32'h5555_5555, 20'hFFFFF, 32'h0000_0011);
    send_request(32'h0000_0006, 20'h00000, 32'h0000_0012);
    send_request(32'h0000_000B, 20'h00000, 32'h0000_0013);

    for (int p = 0; p < NPHASE; p++) begin
      if (p == NPHASE - 1) write_capacity(CAP_W'($urandom_range(0, 31)));
      else write_capacity(PHASE_CAP[p]);
      gaps_on = (p != NPHASE - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (gaps_on) idle_gap();
        random_request();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== code_block_cache_lru.f =====
sv/cbcl_pkg.sv
sv/cbcl_ctrl.sv
sv/cbcl_dpath.sv
sv/code_block_cache_lru.sv
tb/sv/cbcl_checker.sv
tb/sv/tb_top.sv
